// ===== rtl/prsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prsu_pkg
// Shared codes, constants and lane operand type for the point rotate/scale
// unit.
// ----------------------------------------------------------------------------
package prsu_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int TRIG_W  = 16;
	localparam int MUL_W   = 31;
	localparam int PROD_W  = DIFF_W + MUL_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int RND_W   = 37;
	localparam int TOT_W   = RND_W + 1;
	localparam int IDX_W   = 2;

	localparam int SCALE_FRAC = 28;
	localparam int TRIG_FRAC  = 14;

	// 1.1 and 1/1.1 in Q3.28, rounded to nearest
	localparam logic signed [MUL_W-1:0] SCALE_UP_Q   = 31'sd295279002;
	localparam logic signed [MUL_W-1:0] SCALE_DOWN_Q = 31'sd244032233;

	localparam logic [2:0] FUNC_SCALE_UP   = 3'd0;
	localparam logic [2:0] FUNC_SCALE_DOWN = 3'd1;
	localparam logic [2:0] FUNC_ROT_Z      = 3'd2;
	localparam logic [2:0] FUNC_ROT_Y      = 3'd3;
	localparam logic [2:0] FUNC_ROT_X      = 3'd4;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_COS_STEP = 2'd2;
	localparam logic [IDX_W-1:0] REG_SIN_STEP = 2'd3;

	localparam logic [TRIG_W-1:0] COS_RESET = 16'h4000;

	// one output coordinate: a1*m1 + a2*m2, rounded, plus off
	typedef struct packed {
		logic signed [DIFF_W-1:0] a1;
		logic signed [MUL_W-1:0]  m1;
		logic signed [DIFF_W-1:0] a2;
		logic signed [MUL_W-1:0]  m2;
		logic signed [DIFF_W-1:0] off;
		logic                     scl;
	} lane_op_t;

endpackage
`default_nettype wire

// ===== rtl/prsu_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prsu_lane
// One coordinate lane: two products, sum with round half up, pivot add-back
// and saturation. Two register stages.
// ----------------------------------------------------------------------------
module prsu_lane (
	input  wire                                clk,
	input  wire prsu_pkg::lane_op_t            op_s1,
	output logic signed [prsu_pkg::COORD_W-1:0] res,
	output logic                               clip
);
	import prsu_pkg::*;

	logic signed [PROD_W-1:0] p1_s2;
	logic signed [PROD_W-1:0] p2_s2;
	logic signed [DIFF_W-1:0] off_s2;
	logic                     scl_s2;

	logic signed [RND_W-1:0]  rnd_s3;
	logic signed [DIFF_W-1:0] off_s3;

	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  half;
	logic signed [SUM_W-1:0]  sh_scl;
	logic signed [SUM_W-1:0]  sh_trig;
	logic signed [RND_W-1:0]  rnd;
	logic signed [TOT_W-1:0]  tot;
	logic                     fits;

	always_ff @(posedge clk) begin
		p1_s2  <= $signed(op_s1.a1) * $signed(op_s1.m1);
		p2_s2  <= $signed(op_s1.a2) * $signed(op_s1.m2);
		off_s2 <= op_s1.off;
		scl_s2 <= op_s1.scl;
	end

	always_comb begin
		half    = scl_s2 ? (SUM_W'(1) <<< (SCALE_FRAC - 1)) : (SUM_W'(1) <<< (TRIG_FRAC - 1));
		sum     = SUM_W'(p1_s2) + SUM_W'(p2_s2) + half;
		sh_scl  = sum >>> SCALE_FRAC;
		sh_trig = sum >>> TRIG_FRAC;
		rnd     = scl_s2 ? sh_scl[RND_W-1:0] : sh_trig[RND_W-1:0];
	end

	always_ff @(posedge clk) begin
		rnd_s3 <= rnd;
		off_s3 <= off_s2;
	end

	always_comb begin
		tot  = TOT_W'(rnd_s3) + TOT_W'(off_s3);
		fits = (&tot[TOT_W-1:COORD_W-1]) | ~(|tot[TOT_W-1:COORD_W-1]);
		clip = ~fits;
		if (fits) begin
			res = tot[COORD_W-1:0];
		end else if (tot[TOT_W-1]) begin
			res = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/point_rotate_scale_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotate_scale_unit
// Scales a Q16.16 point about the pivot by 1.1 or 1/1.1, or rotates it about
// the z, y or x axis by the configured step angle, with saturation; any other
// func code passes the point through unchanged.
//   channel   handshake          payload
//   ------    ---------------    -------------------------------------
//   input     start, busy        func, in_x, in_y, in_z
//   result    done (strobe)      out_x, out_y, out_z, clipped
//   config    wr_en              wr_idx, wr_data
//
// One item per cycle; each result passes through operand select, multiply,
// sum/round and add-back/saturate register stages.
// busy is never raised; the result has no back-pressure.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module point_rotate_scale_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [2:0]                          func,
	input  wire  signed [prsu_pkg::COORD_W-1:0] in_x,
	input  wire  signed [prsu_pkg::COORD_W-1:0] in_y,
	input  wire  signed [prsu_pkg::COORD_W-1:0] in_z,
	output logic                                done,
	output logic signed [prsu_pkg::COORD_W-1:0] out_x,
	output logic signed [prsu_pkg::COORD_W-1:0] out_y,
	output logic signed [prsu_pkg::COORD_W-1:0] out_z,
	output logic                                clipped,
	input  wire                                 wr_en,
	input  wire  [prsu_pkg::IDX_W-1:0]          wr_idx,
	input  wire  [prsu_pkg::COORD_W-1:0]        wr_data
);
	import prsu_pkg::*;

	localparam logic signed [DIFF_W-1:0] ZERO_D = '0;
	localparam logic signed [MUL_W-1:0]  ZERO_M = '0;

	logic [COORD_W-1:0] center_x_q;
	logic [COORD_W-1:0] center_y_q;
	logic [TRIG_W-1:0]  cos_step_q;
	logic [TRIG_W-1:0]  sin_step_q;

	logic signed [DIFF_W-1:0] cx, cy, x, y, z, dx, dy;
	logic signed [MUL_W-1:0]  c, s, ns, k;
	lane_op_t lx, ly, lz;
	lane_op_t lx_s1, ly_s1, lz_s1;
	logic valid_s1, valid_s2, valid_s3;
	logic accept;
	logic signed [COORD_W-1:0] rx, ry, rz;
	logic clx, cly, clz;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			cos_step_q <= COS_RESET;
			sin_step_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_CENTER_X: center_x_q <= wr_data;
				REG_CENTER_Y: center_y_q <= wr_data;
				REG_COS_STEP: cos_step_q <= wr_data[TRIG_W-1:0];
				REG_SIN_STEP: sin_step_q <= wr_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cx = DIFF_W'($signed(center_x_q));
		cy = DIFF_W'($signed(center_y_q));
		x  = DIFF_W'(in_x);
		y  = DIFF_W'(in_y);
		z  = DIFF_W'(in_z);
		dx = x - cx;
		dy = y - cy;
		c  = MUL_W'($signed(cos_step_q));
		s  = MUL_W'($signed(sin_step_q));
		ns = -s;
		k  = (func == FUNC_SCALE_UP) ? SCALE_UP_Q : SCALE_DOWN_Q;

		// default: coordinate passes through via the offset term
		lx = '{a1: ZERO_D, m1: ZERO_M, a2: ZERO_D, m2: ZERO_M, off: x, scl: 1'b0};
		ly = '{a1: ZERO_D, m1: ZERO_M, a2: ZERO_D, m2: ZERO_M, off: y, scl: 1'b0};
		lz = '{a1: ZERO_D, m1: ZERO_M, a2: ZERO_D, m2: ZERO_M, off: z, scl: 1'b0};

		case (func)
			FUNC_SCALE_UP, FUNC_SCALE_DOWN: begin
				lx = '{a1: dx, m1: k, a2: ZERO_D, m2: ZERO_M, off: cx, scl: 1'b1};
				ly = '{a1: dy, m1: k, a2: ZERO_D, m2: ZERO_M, off: cy, scl: 1'b1};
				lz = '{a1: z, m1: k, a2: ZERO_D, m2: ZERO_M, off: ZERO_D, scl: 1'b1};
			end
			FUNC_ROT_Z: begin
				lx = '{a1: dx, m1: c, a2: dy, m2: ns, off: cx, scl: 1'b0};
				ly = '{a1: dx, m1: s, a2: dy, m2: c, off: cy, scl: 1'b0};
			end
			FUNC_ROT_Y: begin
				lx = '{a1: dx, m1: c, a2: z, m2: s, off: cx, scl: 1'b0};
				lz = '{a1: z, m1: c, a2: dx, m2: ns, off: ZERO_D, scl: 1'b0};
			end
			FUNC_ROT_X: begin
				ly = '{a1: dy, m1: c, a2: z, m2: s, off: cy, scl: 1'b0};
				lz = '{a1: z, m1: c, a2: dy, m2: ns, off: ZERO_D, scl: 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		lx_s1 <= lx;
		ly_s1 <= ly;
		lz_s1 <= lz;
	end

	prsu_lane u_lane_x (.clk(clk), .op_s1(lx_s1), .res(rx), .clip(clx));
	prsu_lane u_lane_y (.clk(clk), .op_s1(ly_s1), .res(ry), .clip(cly));
	prsu_lane u_lane_z (.clk(clk), .op_s1(lz_s1), .res(rz), .clip(clz));

	always_ff @(posedge clk) begin
		out_x   <= rx;
		out_y   <= ry;
		out_z   <= rz;
		clipped <= clx | cly | clz;
	end

`ifndef NO_ASSERTIONS
	localparam logic [COORD_W-1:0] RAIL_HI = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] RAIL_LO = {1'b1, {(COORD_W-1){1'b0}}};

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(valid_s1, 3))
		else $error("result strobe out of step with accepted item");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (out_x == RAIL_HI || out_x == RAIL_LO ||
			out_y == RAIL_HI || out_y == RAIL_LO ||
			out_z == RAIL_HI || out_z == RAIL_LO))
		else $error("clip reported without a saturated coordinate");

	a_unused_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		($past(accept && (func > FUNC_ROT_X), 4) && done)
		|-> !clipped)
		else $error("pass-through item reported a clip");
`endif

endmodule
`default_nettype wire
